>>> rtl/core/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg: shared types and constants for the limit order matcher
// Book depth, field widths, request codes and status codes.
// ----------------------------------------------------------------------------
package lom_pkg;

	localparam int ORDER_SLOTS = 32;
	localparam int SLOT_W      = $clog2(ORDER_SLOTS);
	localparam int ARRIVAL_W   = 48;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 168;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		REQ_NEW     = 2'd0,
		REQ_CANCEL  = 2'd1,
		REQ_REPLACE = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_UNKNOWN   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	localparam logic KIND_TRADE    = 1'b0;
	localparam logic KIND_COMPLETE = 1'b1;
	localparam logic SIDE_BUY      = 1'b0;

endpackage

>>> rtl/core/limit_order_matcher_unit.sv
// ----------------------------------------------------------------------------
// limit_order_matcher_unit: price-time priority limit order book
// Takes new, cancel and replace requests and returns trades and one
// completion per request, using one sequential scan unit over the book.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Content
// --------  ---  -----------------------------------------------------------
// s_*       in   request: tuser = req_type; tdata = order_id, side, price,
//                quantity
// m_*       out  result: tuser = result_kind; tlast = last; tdata = status,
//                buy_id, sell_id, trade_price, trade_quantity, rested_quantity
//
// Flow: a request is taken only while the unit is idle. A cancel, replace
// or well-formed new order first scans the book for its id, one slot per
// cycle. Every fill then costs a best-price scan of the whole book and a
// decision step, and each result waits in the output register until taken.
// The sequential scan unit sets this pace.
// Reset empties the book at once (valid bits only) and clears the arrival
// counter. A stalled output holds the unit; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module limit_order_matcher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// from bit 0: order_id[31:0], side[32], price[64:33], quantity[96:65], zeros
	input  logic [lom_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type[1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// from bit 0: status[2:0], buy_id[34:3], sell_id[66:35], trade_price[97:67],
	// trade_quantity[129:98], rested_quantity[161:130], zeros
	output logic [lom_pkg::OUT_DATA_W-1:0]  m_tdata,
	// result_kind[0]
	output logic                            m_tuser,
	output logic                            m_tlast
);
	import lom_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIND  = 6'b000010,
		S_FDONE = 6'b000100,
		S_SCAN  = 6'b001000,
		S_SDONE = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	// Book storage. Only valid slots are ever read, so the payload has no reset.
	logic [ORDER_SLOTS-1:0] valid_q;
	logic [31:0]            slot_id_q    [ORDER_SLOTS];
	logic                   slot_side_q  [ORDER_SLOTS];
	logic [31:0]            slot_price_q [ORDER_SLOTS];
	logic [31:0]            slot_qty_q   [ORDER_SLOTS];
	logic [ARRIVAL_W-1:0]   slot_arr_q   [ORDER_SLOTS];
	logic [ARRIVAL_W-1:0]   arrival_q;

	// Request being worked on.
	req_type_t   req_q;
	logic [31:0] id_q;
	logic        side_q;
	logic [31:0] price_q;
	logic [31:0] qty_q;
	logic        bad_pq_q;

	// Scan unit state.
	slot_idx_t            idx_q;
	logic                 found_q;
	slot_idx_t            found_idx_q;
	logic                 found_side_q;
	logic                 best_valid_q;
	slot_idx_t            best_idx_q;
	logic [31:0]          best_price_q;
	logic [ARRIVAL_W-1:0] best_arr_q;
	logic [31:0]          best_qty_q;
	logic [31:0]          best_id_q;

	// Output register.
	logic        out_valid_q;
	logic        out_kind_q;
	status_t     out_status_q;
	logic [31:0] out_buy_q;
	logic [31:0] out_sell_q;
	logic [30:0] out_price_q;
	logic [31:0] out_tq_q;
	logic [31:0] out_rest_q;
	logic        out_last_q;

	// Input field views.
	logic [31:0] in_id;
	logic        in_side;
	logic [31:0] in_price;
	logic [31:0] in_qty;
	logic        in_bad_pq;
	req_type_t   in_req;

	assign in_id     = s_tdata[31:0];
	assign in_side   = s_tdata[32];
	assign in_price  = s_tdata[64:33];
	assign in_qty    = s_tdata[96:65];
	assign in_req    = req_type_t'(s_tuser);
	assign in_bad_pq = (in_price == 32'd0) || in_price[31] || (in_qty == 32'd0);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_rest_q, out_tq_q, out_price_q, out_sell_q, out_buy_q,
		out_status_q};

	// Shared compare unit: one slot per cycle against the current best.
	logic scan_cand;
	logic scan_better;
	logic id_hit;
	logic idx_last;

	assign idx_last  = (idx_q == slot_idx_t'(ORDER_SLOTS - 1));
	assign id_hit    = valid_q[idx_q] && (slot_id_q[idx_q] == id_q);
	assign scan_cand = valid_q[idx_q] && (slot_side_q[idx_q] != side_q);

	always_comb begin
		if (!best_valid_q) begin
			scan_better = 1'b1;
		end else if (slot_price_q[idx_q] == best_price_q) begin
			scan_better = slot_arr_q[idx_q] < best_arr_q;
		end else if (side_q == SIDE_BUY) begin
			scan_better = slot_price_q[idx_q] < best_price_q;
		end else begin
			scan_better = slot_price_q[idx_q] > best_price_q;
		end
	end

	// Decision on the best resting order.
	logic        crosses;
	logic [31:0] fill_qty;
	logic        fill_en;
	logic        rest_en;
	logic        free_ok;
	slot_idx_t   free_idx;

	assign crosses  = best_valid_q && (qty_q != 32'd0) &&
		((side_q == SIDE_BUY) ? (best_price_q <= price_q) : (best_price_q >= price_q));
	assign fill_qty = (qty_q < best_qty_q) ? qty_q : best_qty_q;
	assign fill_en  = (state_q == S_SDONE) && crosses;

	// Lowest free slot.
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = slot_idx_t'(i);
			end
		end
	end

	assign rest_en = (state_q == S_SDONE) && !crosses && (qty_q != 32'd0) && free_ok;

	// Book payload writes.
	always_ff @(posedge clk) begin
		if (fill_en) begin
			slot_qty_q[best_idx_q] <= best_qty_q - fill_qty;
		end
		if (rest_en) begin
			slot_id_q[free_idx]    <= id_q;
			slot_side_q[free_idx]  <= side_q;
			slot_price_q[free_idx] <= price_q;
			slot_qty_q[free_idx]   <= qty_q;
			slot_arr_q[free_idx]   <= arrival_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			arrival_q    <= '0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q    <= in_req;
						id_q     <= in_id;
						side_q   <= in_side;
						price_q  <= in_price;
						qty_q    <= in_qty;
						bad_pq_q <= in_bad_pq;
						idx_q    <= '0;
						found_q  <= 1'b0;
						if (in_req == REQ_UNUSED ||
							(in_req == REQ_NEW && (in_id == 32'd0 || in_bad_pq))) begin
							out_valid_q  <= 1'b1;
							out_kind_q   <= KIND_COMPLETE;
							out_status_q <= ST_INVALID;
							out_buy_q    <= '0;
							out_sell_q   <= '0;
							out_price_q  <= '0;
							out_tq_q     <= '0;
							out_rest_q   <= '0;
							out_last_q   <= 1'b1;
							state_q      <= S_OUT;
						end else begin
							state_q <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (!found_q && id_hit) begin
						found_q      <= 1'b1;
						found_idx_q  <= idx_q;
						found_side_q <= slot_side_q[idx_q];
					end
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= S_FDONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FDONE: begin
					best_valid_q <= 1'b0;
					idx_q        <= '0;
					out_kind_q   <= KIND_COMPLETE;
					out_buy_q    <= '0;
					out_sell_q   <= '0;
					out_price_q  <= '0;
					out_tq_q     <= '0;
					out_rest_q   <= '0;
					out_last_q   <= 1'b1;
					if (req_q == REQ_NEW) begin
						if (found_q) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_DUPLICATE;
							state_q      <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (!found_q) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_UNKNOWN;
						state_q      <= S_OUT;
					end else if (req_q == REQ_CANCEL) begin
						valid_q[found_idx_q] <= 1'b0;
						out_valid_q          <= 1'b1;
						out_status_q         <= ST_OK;
						state_q              <= S_OUT;
					end else if (bad_pq_q) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_INVALID;
						state_q      <= S_OUT;
					end else begin
						// Replace: pull the order and resubmit on its stored side.
						valid_q[found_idx_q] <= 1'b0;
						side_q               <= found_side_q;
						state_q              <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_cand && scan_better) begin
						best_valid_q <= 1'b1;
						best_idx_q   <= idx_q;
						best_price_q <= slot_price_q[idx_q];
						best_arr_q   <= slot_arr_q[idx_q];
						best_qty_q   <= slot_qty_q[idx_q];
						best_id_q    <= slot_id_q[idx_q];
					end
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= S_SDONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SDONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
					if (crosses) begin
						out_kind_q   <= KIND_TRADE;
						out_status_q <= ST_OK;
						out_buy_q    <= (side_q == SIDE_BUY) ? id_q : best_id_q;
						out_sell_q   <= (side_q == SIDE_BUY) ? best_id_q : id_q;
						out_price_q  <= best_price_q[30:0];
						out_tq_q     <= fill_qty;
						out_rest_q   <= '0;
						out_last_q   <= 1'b0;
						qty_q        <= qty_q - fill_qty;
						if (best_qty_q == fill_qty) begin
							valid_q[best_idx_q] <= 1'b0;
						end
					end else begin
						out_kind_q  <= KIND_COMPLETE;
						out_buy_q   <= '0;
						out_sell_q  <= '0;
						out_price_q <= '0;
						out_tq_q    <= '0;
						out_last_q  <= 1'b1;
						if (qty_q == 32'd0) begin
							out_status_q <= ST_OK;
							out_rest_q   <= '0;
						end else if (free_ok) begin
							valid_q[free_idx] <= 1'b1;
							arrival_q         <= arrival_q + 1'b1;
							out_status_q      <= ST_OK;
							out_rest_q        <= qty_q;
						end else begin
							out_status_q <= ST_FULL;
							out_rest_q   <= '0;
						end
					end
				end
				S_OUT: begin
					if (m_tready) begin
						out_valid_q  <= 1'b0;
						best_valid_q <= 1'b0;
						idx_q        <= '0;
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else if (qty_q == 32'd0) begin
							// Filled completely: go straight to the completion.
							state_q <= S_SDONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for limit_order_matcher_unit
// Drives new, cancel and replace requests into the order book. A behavioral
// book in the bench predicts every trade and completion. A monitor compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import lom_pkg::*;

	// Shape of one result transfer, as the bench predicts it.
	typedef struct {
		logic        kind;
		logic [2:0]  status;
		logic [31:0] buy_id;
		logic [31:0] sell_id;
		logic [30:0] price;
		logic [31:0] qty;
		logic [31:0] rested;
		logic        last;
	} book_result_t;

	// One row of the directed table. A row with reps above one repeats with
	// the order id counting up. When chk is set, the completion of the last
	// repetition must carry the status and rested quantity typed in the row.
	typedef struct {
		req_type_t   rt;
		logic [31:0] id;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
		int          reps;
		bit          chk;
		status_t     want_status;
		logic [31:0] want_rested;
	} req_row_t;

	localparam int NUM_ROWS = 19;
	localparam int RANDOM_REQS = 408;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [1:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	limit_order_matcher_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Shadow copy of the order book.
	bit          book_live  [ORDER_SLOTS];
	logic [31:0] book_id    [ORDER_SLOTS];
	logic        book_side  [ORDER_SLOTS];
	logic [31:0] book_price [ORDER_SLOTS];
	logic [31:0] book_qty   [ORDER_SLOTS];
	logic [47:0] book_stamp [ORDER_SLOTS];
	logic [47:0] stamp_ctr;

	book_result_t pending_results[$];
	int           mismatches;
	bit           calm;        // no random idling on either side while set
	int           rx_hold;     // cycles the result side still holds off

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous upper bound on the whole run.
	initial begin
		#60000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic note_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int book_find(input logic [31:0] id);
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (book_live[i] && book_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void queue_completion(input status_t st, input logic [31:0] rested);
		book_result_t r;
		r = '{kind: KIND_COMPLETE, status: st, buy_id: '0, sell_id: '0, price: '0,
			qty: '0, rested: rested, last: 1'b1};
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Match a checked order against the book, then rest whatever is left.
	function automatic void book_match(input logic [31:0] id, input logic side,
			input logic [31:0] px, input logic [31:0] qty);
		int best;
		int free_slot;
		logic [31:0] fill;
		book_result_t r;
		while (qty != 0) begin
			best = -1;
			for (int i = 0; i < ORDER_SLOTS; i++) begin
				if (!book_live[i] || book_side[i] == side)
					continue;
				if (best < 0)
					best = i;
				else if (book_price[i] == book_price[best]) begin
					if (book_stamp[i] < book_stamp[best])
						best = i;
				end else if (side == SIDE_BUY ? book_price[i] < book_price[best]
						: book_price[i] > book_price[best]) begin
					best = i;
				end
			end
			if (best < 0)
				break;
			if (side == SIDE_BUY ? book_price[best] > px : book_price[best] < px)
				break;
			fill = qty < book_qty[best] ? qty : book_qty[best];
			r = '{kind: KIND_TRADE, status: ST_OK,
				buy_id: side == SIDE_BUY ? id : book_id[best],
				sell_id: side == SIDE_BUY ? book_id[best] : id,
				price: book_price[best][30:0], qty: fill, rested: '0, last: 1'b0};
			pending_results.insert(pending_results.size(), r);
			qty -= fill;
			book_qty[best] -= fill;
			if (book_qty[best] == 0)
				book_live[best] = 0;
		end
		if (qty == 0) begin
			queue_completion(ST_OK, '0);
			return;
		end
		free_slot = -1;
		for (int i = ORDER_SLOTS - 1; i >= 0; i--)
			if (!book_live[i])
				free_slot = i;
		if (free_slot < 0) begin
			queue_completion(ST_FULL, '0);
			return;
		end
		book_live[free_slot]  = 1;
		book_id[free_slot]    = id;
		book_side[free_slot]  = side;
		book_price[free_slot] = px;
		book_qty[free_slot]   = qty;
		book_stamp[free_slot] = stamp_ctr;
		stamp_ctr++;
		queue_completion(ST_OK, qty);
	endfunction

	// Apply one accepted request to the shadow book and queue its results.
	function automatic void book_apply(input req_type_t rt, input logic [31:0] id,
			input logic side, input logic [31:0] px, input logic [31:0] qty);
		bit bad_pq;
		int slot;
		bad_pq = px == 0 || px[31] || qty == 0;
		case (rt)
			REQ_NEW: begin
				if (id == 0 || bad_pq)
					queue_completion(ST_INVALID, '0);
				else if (book_find(id) >= 0)
					queue_completion(ST_DUPLICATE, '0);
				else
					book_match(id, side, px, qty);
			end
			REQ_CANCEL, REQ_REPLACE: begin
				slot = book_find(id);
				if (slot < 0)
					queue_completion(ST_UNKNOWN, '0);
				else if (rt == REQ_CANCEL) begin
					book_live[slot] = 0;
					queue_completion(ST_OK, '0);
				end else if (bad_pq)
					queue_completion(ST_INVALID, '0);
				else begin
					book_live[slot] = 0;
					book_match(id, book_side[slot], px, qty);
				end
			end
			default: queue_completion(ST_INVALID, '0);
		endcase
	endfunction

	// Offer one request and wait for its transfer. Valid stays high from one
	// request to the next unless a random gap is inserted.
	task automatic send_request(input req_type_t rt, input logic [31:0] id,
			input logic side, input logic [31:0] px, input logic [31:0] qty);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rt;
		s_tdata  <= {7'd0, qty, px, side, id};
		do
			@(posedge clk);
		while (!s_tready);
		book_apply(rt, id, side, px, qty);
	endtask

	// Result side: random stalls, a quiet stretch, and long hold-offs on request.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else
			m_tready <= calm || $urandom_range(99) >= 6;
	end

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin
		book_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0)
				note_mismatch("result transfer with nothing predicted");
			else begin
				w = pending_results.pop_front();
				if (m_tuser !== w.kind)
					note_mismatch($sformatf("kind %0b, want %0b", m_tuser, w.kind));
				if (m_tdata[2:0] !== w.status)
					note_mismatch($sformatf("status %0d, want %0d", m_tdata[2:0], w.status));
				if (m_tdata[34:3] !== w.buy_id)
					note_mismatch($sformatf("buy_id %0h, want %0h", m_tdata[34:3], w.buy_id));
				if (m_tdata[66:35] !== w.sell_id)
					note_mismatch($sformatf("sell_id %0h, want %0h", m_tdata[66:35], w.sell_id));
				if (m_tdata[97:67] !== w.price)
					note_mismatch($sformatf("price %0d, want %0d", m_tdata[97:67], w.price));
				if (m_tdata[129:98] !== w.qty)
					note_mismatch($sformatf("trade qty %0d, want %0d", m_tdata[129:98], w.qty));
				if (m_tdata[161:130] !== w.rested)
					note_mismatch($sformatf("rested %0d, want %0d", m_tdata[161:130], w.rested));
				if (m_tdata[167:162] !== 6'd0)
					note_mismatch("padding bits of tdata not zero");
				if (m_tlast !== w.last)
					note_mismatch($sformatf("last %0b, want %0b", m_tlast, w.last));
			end
		end
	end

	initial begin
		req_row_t    rows [NUM_ROWS];
		req_type_t   rt;
		logic [31:0] id, px, qty;
		logic        side;
		int          pick;

		// Directed table: rejections first, then extremes, then a full book
		// and one sell that sweeps every resting bid.
		rows = '{
			'{REQ_CANCEL,  32'd5,        1'b0, 32'd10,         32'd1,  1, 1, ST_UNKNOWN,   32'd0},
			'{REQ_NEW,     32'd0,        1'b0, 32'd10,         32'd1,  1, 1, ST_INVALID,   32'd0},
			'{REQ_NEW,     32'd7,        1'b0, 32'd0,          32'd1,  1, 1, ST_INVALID,   32'd0},
			'{REQ_NEW,     32'd7,        1'b1, 32'h8000_0000,  32'd1,  1, 1, ST_INVALID,   32'd0},
			'{REQ_NEW,     32'd7,        1'b0, 32'hFFFF_FFFF,  32'd1,  1, 1, ST_INVALID,   32'd0},
			'{REQ_NEW,     32'd7,        1'b0, 32'd10,         32'd0,  1, 1, ST_INVALID,   32'd0},
			'{REQ_UNUSED,  32'd7,        1'b0, 32'd10,         32'd1,  1, 1, ST_INVALID,   32'd0},
			'{REQ_NEW,     32'hFFFF_FFFF,1'b0, 32'd100, 32'hFFFF_FFFF, 1, 1, ST_OK, 32'hFFFF_FFFF},
			'{REQ_NEW,     32'hFFFF_FFFF,1'b1, 32'd100,        32'd1,  1, 1, ST_DUPLICATE, 32'd0},
			'{REQ_NEW,     32'd2,        1'b1, 32'h7FFF_FFFF,  32'd1,  1, 1, ST_OK,        32'd1},
			'{REQ_NEW,     32'd3,        1'b1, 32'd1,          32'd10, 1, 0, ST_OK,        32'd0},
			'{REQ_REPLACE, 32'd2,        1'b0, 32'd0,          32'd5,  1, 1, ST_INVALID,   32'd0},
			'{REQ_REPLACE, 32'd2,        1'b0, 32'd50,         32'd0,  1, 1, ST_INVALID,   32'd0},
			'{REQ_REPLACE, 32'd99,       1'b0, 32'd50,         32'd5,  1, 1, ST_UNKNOWN,   32'd0},
			'{REQ_REPLACE, 32'd2,        1'b0, 32'd50,         32'd5,  1, 0, ST_OK,        32'd0},
			'{REQ_CANCEL,  32'hFFFF_FFFF,1'b0, 32'd0,          32'd0,  1, 1, ST_OK,        32'd0},
			'{REQ_CANCEL,  32'd0,        1'b0, 32'd0,          32'd0,  1, 1, ST_UNKNOWN,   32'd0},
			'{REQ_NEW,     32'd1000,     1'b0, 32'd10,         32'd1,  33, 1, ST_FULL,     32'd0},
			'{REQ_NEW,     32'd2000,     1'b1, 32'd1,          32'd40, 1, 1, ST_OK,        32'd8}
		};

		mismatches = 0;
		calm       = 0;
		rx_hold    = 0;
		stamp_ctr  = '0;
		foreach (book_live[i])
			book_live[i] = 0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_NEW;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[r]) begin
			for (int k = 0; k < rows[r].reps; k++)
				send_request(rows[r].rt, rows[r].id + k, rows[r].side, rows[r].price,
					rows[r].qty);
			if (rows[r].chk) begin
				pending_results[$].status = rows[r].want_status;
				pending_results[$].rested = rows[r].want_rested;
			end
		end
		// Clear out the book before the random part: only the sweeping sell
		// is still resting.
		send_request(REQ_CANCEL, 32'd2000, 1'b0, 32'd1, 32'd1);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			calm = n >= 200 && n < 280;
			if (n == 120)
				rx_hold = 600;  // the block fills and stalls its input meanwhile
			if (n == 330)
				wait (pending_results.size() == 0);

			pick = $urandom_range(99);
			rt = pick < 62 ? REQ_NEW : pick < 78 ? REQ_CANCEL : pick < 96 ? REQ_REPLACE
				: REQ_UNUSED;
			id   = $urandom_range(99) < 4 ? $urandom : $urandom_range(40, 1);
			side = $urandom_range(1);
			pick = $urandom_range(99);
			px   = pick < 5 ? $urandom : pick < 8 ? 32'd0 : $urandom_range(108, 92);
			pick = $urandom_range(99);
			qty  = pick < 5 ? $urandom : pick < 7 ? 32'd0 : $urandom_range(40, 1);
			send_request(rt, id, side, px, qty);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
